// ===== rtl/core/srca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srca_pkg
// Shared types and constants for the sensor reading converter and averager.
// ----------------------------------------------------------------------------
package srca_pkg;

    localparam int CODE_W      = 20;
    localparam int HUM_W       = 14;
    localparam int TEMP_W      = 15;
    localparam int SUM_W       = 17;   // signed window sum of three temperatures
    localparam int DVD_W       = 16;   // magnitude of either window sum
    localparam int CNT_W       = 2;
    localparam int WIN_DEPTH   = 3;
    localparam int CODE_SHIFT  = 20;
    localparam int DIV_STEPS   = DVD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [15:0] TEMP_OFFSET = 16'd5000;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_WIN,
        S_SUM,
        S_DIV,
        S_STORE
    } t_state;

    typedef struct packed {
        logic capture;    // latch frame codes
        logic convert;    // scale codes to engineering units
        logic win_write;  // push converted values into the windows
        logic div_load;   // form sums and load the divider
        logic div_step;   // one quotient bit per lane
        logic out_load;   // move results to the output register
    } t_cmd;

endpackage

// ===== rtl/core/sensor_reading_convert_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_reading_convert_average
// Humidity/temperature frame converter with a three-point moving average.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes the five measurement bytes of one
//   sensor frame as a word. Output channel (o_valid / i_ready) returns the
//   converted humidity and temperature of that frame plus the window mean.
//   Each frame passes through convert, window write, sum, 16 divide steps
//   and store before o_valid rises. A new word is accepted only after the
//   last one is stored; the one-bit-per-cycle divider serves both lanes.
//   The output register parts the two sides: a new frame is accepted while
//   the last result still waits. If the receiver stalls, the next result
//   waits in the divider until the output register frees up, and o_ready
//   stays low meanwhile.
//   Reset clears both windows, the write slot and the fill count, and drops
//   o_valid; the first result after reset is the frame's own value, the
//   second the mean of two, every later one the mean of three.
// ----------------------------------------------------------------------------
module sensor_reading_convert_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_hum_high,
    input  logic [7:0]  i_hum_mid,
    input  logic [7:0]  i_shared_nibbles,
    input  logic [7:0]  i_temp_mid,
    input  logic [7:0]  i_temp_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [14:0] o_temperature_avg,
    output logic [13:0] o_humidity_avg,
    output logic signed [14:0] o_temperature_now,
    output logic [13:0] o_humidity_now
);

    // command bundle from sequencer to datapath
    srca_pkg::t_cmd cmd;

    srca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // unpack, scale, window, divide by fill count (1..3), hold results
    srca_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_hum_high        (i_hum_high),
        .i_hum_mid         (i_hum_mid),
        .i_shared_nibbles  (i_shared_nibbles),
        .i_temp_mid        (i_temp_mid),
        .i_temp_low        (i_temp_low),
        .o_temperature_avg (o_temperature_avg),
        .o_humidity_avg    (o_humidity_avg),
        .o_temperature_now (o_temperature_now),
        .o_humidity_now    (o_humidity_now)
    );

endmodule

// ===== rtl/core/srca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srca_ctrl
// Sequencer: steps one frame through convert, window, divide and store.
// ----------------------------------------------------------------------------
module srca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output srca_pkg::t_cmd  o_cmd
);

    srca_pkg::t_state                    r_state, n_state;
    logic [srca_pkg::STEP_W-1:0]         r_step, n_step;
    logic                                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srca_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            srca_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = srca_pkg::S_CONV;
                end
            end
            srca_pkg::S_CONV: begin
                o_cmd.convert = 1'b1;
                n_state       = srca_pkg::S_WIN;
            end
            srca_pkg::S_WIN: begin
                o_cmd.win_write = 1'b1;
                n_state         = srca_pkg::S_SUM;
            end
            srca_pkg::S_SUM: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = srca_pkg::S_DIV;
            end
            srca_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == srca_pkg::STEP_W'(srca_pkg::DIV_STEPS - 1)) begin
                    n_state = srca_pkg::S_STORE;
                end
            end
            srca_pkg::S_STORE: begin
                // wait here while the previous word is still unclaimed
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = srca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srca_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== rtl/core/srca_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srca_dpath
// Code unpack, unit scaling, three-entry windows, serial divide, output regs.
// ----------------------------------------------------------------------------
module srca_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  srca_pkg::t_cmd                     i_cmd,
    input  logic [7:0]                         i_hum_high,
    input  logic [7:0]                         i_hum_mid,
    input  logic [7:0]                         i_shared_nibbles,
    input  logic [7:0]                         i_temp_mid,
    input  logic [7:0]                         i_temp_low,
    output logic signed [srca_pkg::TEMP_W-1:0] o_temperature_avg,
    output logic [srca_pkg::HUM_W-1:0]         o_humidity_avg,
    output logic signed [srca_pkg::TEMP_W-1:0] o_temperature_now,
    output logic [srca_pkg::HUM_W-1:0]         o_humidity_now
);

    // frame codes
    logic [srca_pkg::CODE_W-1:0] r_hcode, r_tcode;

    // converted values
    logic [srca_pkg::HUM_W-1:0]         r_hum_now;
    logic signed [srca_pkg::TEMP_W-1:0] r_temp_now;

    // windows
    logic signed [srca_pkg::TEMP_W-1:0] r_twin [srca_pkg::WIN_DEPTH];
    logic [srca_pkg::HUM_W-1:0]         r_hwin [srca_pkg::WIN_DEPTH];
    logic [srca_pkg::CNT_W-1:0]         r_slot, r_count;

    // divider, two lanes sharing the divisor
    logic [srca_pkg::DVD_W-1:0] r_tq, r_hq;
    logic [1:0]                 r_tr, r_hr;
    logic [srca_pkg::CNT_W-1:0] r_dsr;
    logic                       r_tneg;

    // output register
    logic signed [srca_pkg::TEMP_W-1:0] r_o_tavg, r_o_tnow;
    logic [srca_pkg::HUM_W-1:0]         r_o_havg, r_o_hnow;

    logic [33:0]                hprod;
    logic [34:0]                tprod;
    logic [15:0]                tconv;
    logic [srca_pkg::SUM_W-1:0] tsum, tsum_neg;
    logic [srca_pkg::DVD_W-1:0] hsum;
    logic [2:0]                 ttrial, htrial, tdiff, hdiff;
    logic                       tbit, hbit;
    logic [srca_pkg::TEMP_W-1:0] tq_signed;

    // scaling: code * scale >> 20, truncating; temperature then minus the offset
    assign hprod = 34'(r_hcode) * 34'(srca_pkg::HUM_SCALE);
    assign tprod = 35'(r_tcode) * 35'(srca_pkg::TEMP_SCALE);
    assign tconv = {1'b0, tprod[34:srca_pkg::CODE_SHIFT]} - srca_pkg::TEMP_OFFSET;

    always_comb begin
        tsum = {{2{r_twin[0][14]}}, r_twin[0]}
             + {{2{r_twin[1][14]}}, r_twin[1]}
             + {{2{r_twin[2][14]}}, r_twin[2]};
        hsum = {2'b00, r_hwin[0]} + {2'b00, r_hwin[1]} + {2'b00, r_hwin[2]};
        tsum_neg = -tsum;
    end

    // restoring divide step, divisor is 1..3 so remainder stays in two bits
    always_comb begin
        ttrial = {r_tr, r_tq[srca_pkg::DVD_W-1]};
        htrial = {r_hr, r_hq[srca_pkg::DVD_W-1]};
        tdiff  = ttrial - {1'b0, r_dsr};
        hdiff  = htrial - {1'b0, r_dsr};
        tbit   = (ttrial >= {1'b0, r_dsr});
        hbit   = (htrial >= {1'b0, r_dsr});
        tq_signed = r_tneg ? -r_tq[srca_pkg::TEMP_W-1:0] : r_tq[srca_pkg::TEMP_W-1:0];
    end

    // window state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < srca_pkg::WIN_DEPTH; i++) begin
                r_twin[i] <= '0;
                r_hwin[i] <= '0;
            end
            r_slot  <= '0;
            r_count <= '0;
        end else if (i_cmd.win_write) begin
            r_twin[r_slot] <= r_temp_now;
            r_hwin[r_slot] <= r_hum_now;
            r_slot <= (r_slot == srca_pkg::CNT_W'(srca_pkg::WIN_DEPTH - 1))
                      ? '0 : r_slot + 1'b1;
            if (r_count != srca_pkg::CNT_W'(srca_pkg::WIN_DEPTH)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hcode <= {i_hum_high, i_hum_mid, i_shared_nibbles[7:4]};
            r_tcode <= {i_shared_nibbles[3:0] & srca_pkg::NIBBLE_MASK, i_temp_mid, i_temp_low};
        end
        if (i_cmd.convert) begin
            r_hum_now  <= hprod[33:srca_pkg::CODE_SHIFT];
            r_temp_now <= tconv[srca_pkg::TEMP_W-1:0];
        end
        if (i_cmd.div_load) begin
            r_tneg <= tsum[srca_pkg::SUM_W-1];
            r_tq   <= tsum[srca_pkg::SUM_W-1] ? tsum_neg[srca_pkg::DVD_W-1:0]
                                              : tsum[srca_pkg::DVD_W-1:0];
            r_hq   <= hsum;
            r_tr   <= '0;
            r_hr   <= '0;
            r_dsr  <= r_count;
        end else if (i_cmd.div_step) begin
            r_tq <= {r_tq[srca_pkg::DVD_W-2:0], tbit};
            r_hq <= {r_hq[srca_pkg::DVD_W-2:0], hbit};
            r_tr <= tbit ? tdiff[1:0] : ttrial[1:0];
            r_hr <= hbit ? hdiff[1:0] : htrial[1:0];
        end
        if (i_cmd.out_load) begin
            r_o_tavg <= tq_signed;
            r_o_havg <= r_hq[srca_pkg::HUM_W-1:0];
            r_o_tnow <= r_temp_now;
            r_o_hnow <= r_hum_now;
        end
    end

    assign o_temperature_avg = r_o_tavg;
    assign o_humidity_avg    = r_o_havg;
    assign o_temperature_now = r_o_tnow;
    assign o_humidity_now    = r_o_hnow;

endmodule
